>>> sv/tlbpw_pkg.sv
// Shared types, sizes and codes for the TLB and page walk block.
package tlbpw_pkg;

  localparam int PAGE_OFFSET_BITS = 12;
  localparam int DIR_INDEX_BITS   = 5;
  localparam int TABLE_INDEX_BITS = 5;
  localparam int TLB_DEPTH        = 64;
  localparam int FRAME_BITS       = 10;

  localparam int VADDR_W  = 22;
  localparam int PADDR_W  = 22;
  localparam int FRAME_W  = 10;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;

  localparam int VPN_BITS    = DIR_INDEX_BITS + TABLE_INDEX_BITS;
  localparam int TABLE_COUNT = 1 << VPN_BITS;
  localparam int SLOT_W      = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

  localparam logic [OPCODE_W-1:0] OPC_XLATE = 2'd0;
  localparam logic [OPCODE_W-1:0] OPC_MAP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OPC_INVAL = 2'd2;
  localparam logic [OPCODE_W-1:0] OPC_RSVD  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_TLB_HIT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WALK_HIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVAL    = 3'd5;

  typedef enum logic [1:0] {
    OP_XLATE,
    OP_MAP,
    OP_INVAL,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t                    op;
    logic                        va_zero;
    logic [VPN_BITS-1:0]         vpn;
    logic [PAGE_OFFSET_BITS-1:0] off;
    logic [FRAME_BITS-1:0]       frm;
  } item_t;

  // queue head toward the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // back end control toward the front end
  typedef struct packed {
    logic pop;
    logic init_done;
  } back_ctl_t;

  function automatic logic [PADDR_W-1:0] join_addr(
    input logic [FRAME_BITS-1:0]       f,
    input logic [PAGE_OFFSET_BITS-1:0] o
  );
    return PADDR_W'({f, o});
  endfunction

endpackage

>>> sv/tlbpw_front.sv
// Front end: accepts input words, decodes them and queues them for the back end.
module tlbpw_front import tlbpw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VADDR_W-1:0]  in_vaddr,
  input  logic [FRAME_W-1:0]  in_frame,
  input  back_ctl_t           ctl,
  output q_head_t             head
);

  item_t       q_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       dec;
  logic        push;

  always_comb begin
    unique case (in_opcode)
      OPC_XLATE: dec.op = OP_XLATE;
      OPC_MAP:   dec.op = OP_MAP;
      OPC_INVAL: dec.op = OP_INVAL;
      default:   dec.op = OP_NONE;
    endcase
    dec.va_zero = (in_vaddr == '0);
    dec.vpn     = in_vaddr[PAGE_OFFSET_BITS +: VPN_BITS];
    dec.off     = in_vaddr[PAGE_OFFSET_BITS-1:0];
    dec.frm     = FRAME_BITS'(in_frame);
  end

  assign in_ready   = ctl.init_done && (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ ctl.pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, ctl.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= dec;
  end

endmodule

>>> sv/tlbpw_back.sv
// Back end: TLB and page table storage, lookup, walk, map, invalidate, result register.
module tlbpw_back import tlbpw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  q_head_t             head,
  output back_ctl_t           ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PADDR_W-1:0]  out_paddr,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_lookups,
  output logic [COUNT_W-1:0]  out_hits,
  output logic [COUNT_W-1:0]  out_misses
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL} state_t;

  state_t state_r;

  logic [VPN_BITS-1:0]   tag_mem [TLB_DEPTH];
  logic [FRAME_BITS-1:0] frm_mem [TLB_DEPTH];
  logic [FRAME_BITS-1:0] tbl_mem [TABLE_COUNT];

  logic [TLB_DEPTH-1:0]       tlb_valid_r;
  logic [TLB_DEPTH-1:0]       tag_wr_r;     // tag written since reset
  logic [(1<<DIR_INDEX_BITS)-1:0] dir_r;
  logic [VPN_BITS-1:0]        clr_r;
  item_t                      cur_r;
  logic [VPN_BITS-1:0]        tag_q_r;
  logic [FRAME_BITS-1:0]      frm_q_r;
  logic [FRAME_BITS-1:0]      tbl_q_r;
  logic                       out_valid_r;
  logic [PADDR_W-1:0]         paddr_r, paddr_nxt;
  logic [STATUS_W-1:0]        status_r, status_nxt;
  logic [COUNT_W-1:0]         lookups_r, hits_r, misses_r;

  logic [SLOT_W-1:0]          cur_slot, head_slot;
  logic [DIR_INDEX_BITS-1:0]  cur_dir;
  logic [VPN_BITS-1:0]        tag_eff;
  logic                       hit, walk_ok, out_free, fire;

  assign head_slot = SLOT_W'(head.item.vpn % TLB_DEPTH);
  assign cur_slot  = SLOT_W'(cur_r.vpn % TLB_DEPTH);
  assign cur_dir   = cur_r.vpn[VPN_BITS-1 -: DIR_INDEX_BITS];
  assign tag_eff   = tag_wr_r[cur_slot] ? tag_q_r : '0;
  assign hit       = tlb_valid_r[cur_slot] && (tag_eff == cur_r.vpn);
  assign walk_ok   = dir_r[cur_dir] && (tbl_q_r != '0);
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = (state_r == S_EVAL) && out_free;

  assign ctl.pop       = (state_r == S_IDLE) && head.valid;
  assign ctl.init_done = (state_r != S_CLEAR);

  assign out_valid   = out_valid_r;
  assign out_paddr   = paddr_r;
  assign out_status  = status_r;
  assign out_lookups = lookups_r;
  assign out_hits    = hits_r;
  assign out_misses  = misses_r;

  // result payload for the word under evaluation
  always_comb begin
    paddr_nxt  = '0;
    status_nxt = ST_FAULT;
    unique case (cur_r.op)
      OP_XLATE: begin
        if (!cur_r.va_zero) begin
          if (hit) begin
            paddr_nxt  = join_addr(frm_q_r, cur_r.off);
            status_nxt = ST_TLB_HIT;
          end else if (walk_ok) begin
            paddr_nxt  = join_addr(tbl_q_r, cur_r.off);
            status_nxt = ST_WALK_HIT;
          end
        end
      end
      OP_MAP:   status_nxt = (tbl_q_r == '0) ? ST_MAPPED : ST_ALREADY;
      OP_INVAL: status_nxt = ST_INVAL;
      default: ;
    endcase
  end

  // storage reads and writes
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      tag_q_r <= tag_mem[head_slot];
      frm_q_r <= frm_mem[head_slot];
      tbl_q_r <= tbl_mem[head.item.vpn];
    end
    if (state_r == S_CLEAR) begin
      tbl_mem[clr_r] <= '0;
    end else if (fire && cur_r.op == OP_MAP && tbl_q_r == '0) begin
      tbl_mem[cur_r.vpn] <= cur_r.frm;
    end
    if (fire && cur_r.op == OP_XLATE && !cur_r.va_zero && !hit && walk_ok) begin
      tag_mem[cur_slot] <= cur_r.vpn;
      frm_mem[cur_slot] <= tbl_q_r;
    end
    if (ctl.pop) cur_r <= head.item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      tlb_valid_r <= '0;
      tag_wr_r    <= '0;
      dir_r       <= '0;
      out_valid_r <= 1'b0;
      lookups_r   <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
    end else begin
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (out_free) begin
            state_r  <= S_IDLE;
            paddr_r  <= paddr_nxt;
            status_r <= status_nxt;
            unique case (cur_r.op)
              OP_XLATE: begin
                if (!cur_r.va_zero) begin
                  lookups_r <= lookups_r + 1'b1;
                  if (hit) begin
                    hits_r <= hits_r + 1'b1;
                  end else begin
                    misses_r <= misses_r + 1'b1;
                    if (walk_ok) begin
                      tlb_valid_r[cur_slot] <= 1'b1;
                      tag_wr_r[cur_slot]    <= 1'b1;
                    end
                  end
                end
              end
              OP_MAP: begin
                dir_r[cur_dir] <= 1'b1;
              end
              OP_INVAL: begin
                if (tag_eff == cur_r.vpn) tlb_valid_r[cur_slot] <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/tlb_and_two_level_page_walk.sv
// MMU top level: direct-mapped TLB over a two-level page table.
// After reset the block sweeps the 1024-entry page table to zero, one entry a
// cycle, so in_ready stays low until the sweep is done. Then the back end pops
// a word and reads the TLB tag/frame and page table entry from their
// synchronous memories at once, then evaluates it, writes back (TLB fill,
// table map, invalidate) and loads the result register once that register
// is free; it takes no new word until the last one is evaluated. A two-deep
// queue between decode and execution lets input words land while a result
// waits in the output register. Opcode 0 translates, 1 maps a page if its
// table entry is empty, 2 clears the TLB entry whose tag matches, 3 faults.
// Counters for lookups, hits and misses wrap and ride along on every result.
module tlb_and_two_level_page_walk import tlbpw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VADDR_W-1:0]  in_vaddr,
  input  logic [FRAME_W-1:0]  in_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PADDR_W-1:0]  out_paddr,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_lookups,
  output logic [COUNT_W-1:0]  out_hits,
  output logic [COUNT_W-1:0]  out_misses
);

  q_head_t   head;
  back_ctl_t ctl;

  tlbpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_vaddr  (in_vaddr),
    .in_frame  (in_frame),
    .ctl       (ctl),
    .head      (head)
  );

  tlbpw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_paddr   (out_paddr),
    .out_status  (out_status),
    .out_lookups (out_lookups),
    .out_hits    (out_hits),
    .out_misses  (out_misses)
  );

endmodule

>>> sv/tlbpw_check.sv
// Port-level checker for the MMU block, bound to the top level.
module tlbpw_check import tlbpw_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PADDR_W-1:0]  out_paddr,
  input logic [STATUS_W-1:0] out_status,
  input logic [COUNT_W-1:0]  out_lookups,
  input logic [COUNT_W-1:0]  out_hits,
  input logic [COUNT_W-1:0]  out_misses
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_paddr) && $stable(out_status))
    else $error("stalled result changed");

  a_paddr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TLB_HIT && out_status != ST_WALK_HIT |-> out_paddr == '0)
    else $error("paddr nonzero without translation");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lookups == COUNT_W'(out_hits + out_misses))
    else $error("lookups differ from hits plus misses");

endmodule

bind tlb_and_two_level_page_walk tlbpw_check u_tlbpw_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_paddr   (out_paddr),
  .out_status  (out_status),
  .out_lookups (out_lookups),
  .out_hits    (out_hits),
  .out_misses  (out_misses)
);

>>> verif/tlb_and_two_level_page_walk_tb.sv
// Self-checking testbench for the TLB and two-level page walk block.
module tlb_and_two_level_page_walk_tb;
  import tlbpw_pkg::*;

  typedef struct {
    logic [PADDR_W-1:0]  paddr;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  lookups;
    logic [COUNT_W-1:0]  hits;
    logic [COUNT_W-1:0]  misses;
  } mmu_result_t;

  // Scoreboard: shadow MMU state plus the queue of pending results.
  class mmu_scoreboard;
    logic [VPN_BITS-1:0]   tag_shadow [TLB_DEPTH];
    logic [FRAME_BITS-1:0] frm_shadow [TLB_DEPTH];
    logic                  tlb_ok [TLB_DEPTH];
    logic                  dir_ok [1 << DIR_INDEX_BITS];
    logic [FRAME_BITS-1:0] pte [TABLE_COUNT];
    logic [COUNT_W-1:0]    n_lookup, n_hit, n_miss;
    mmu_result_t           pending [$];
    int                    errors;

    function new();
      foreach (tag_shadow[i]) begin
        tag_shadow[i] = '0; frm_shadow[i] = '0; tlb_ok[i] = 1'b0;
      end
      foreach (dir_ok[i]) dir_ok[i] = 1'b0;
      foreach (pte[i]) pte[i] = '0;
      n_lookup = '0; n_hit = '0; n_miss = '0; errors = 0;
    endfunction

    // Apply one accepted word to the shadow state, queue its result.
    function void note_word(logic [OPCODE_W-1:0] op, logic [VADDR_W-1:0] va,
                            logic [FRAME_W-1:0] frm);
      logic [PAGE_OFFSET_BITS-1:0] off;
      logic [VPN_BITS-1:0]         vpn;
      int                          slot, dir;
      mmu_result_t                 r;
      off  = va[PAGE_OFFSET_BITS-1:0];
      vpn  = va[PAGE_OFFSET_BITS +: VPN_BITS];
      dir  = int'(vpn >> TABLE_INDEX_BITS);
      slot = vpn % TLB_DEPTH;
      r.paddr = '0;
      r.status = ST_FAULT;
      if (op == OPC_XLATE) begin
        if (va != '0) begin
          n_lookup++;
          if (tlb_ok[slot] && tag_shadow[slot] == vpn) begin
            n_hit++;
            r.paddr = PADDR_W'({frm_shadow[slot], off});
            r.status = ST_TLB_HIT;
          end else begin
            n_miss++;
            if (dir_ok[dir] && pte[vpn] != '0) begin
              tag_shadow[slot] = vpn;
              frm_shadow[slot] = pte[vpn];
              tlb_ok[slot] = 1'b1;
              r.paddr = PADDR_W'({pte[vpn], off});
              r.status = ST_WALK_HIT;
            end
          end
        end
      end else if (op == OPC_MAP) begin
        dir_ok[dir] = 1'b1;
        if (pte[vpn] == '0) begin
          pte[vpn] = frm[FRAME_BITS-1:0];
          r.status = ST_MAPPED;
        end else r.status = ST_ALREADY;
      end else if (op == OPC_INVAL) begin
        if (tag_shadow[slot] == vpn) tlb_ok[slot] = 1'b0;
        r.status = ST_INVAL;
      end
      r.lookups = n_lookup; r.hits = n_hit; r.misses = n_miss;
      pending.push_back(r);
    endfunction

    function void check_result(mmu_result_t got);
      mmu_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result word: status %0d paddr %h", got.status, got.paddr);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.paddr !== exp.paddr) begin
        $error("paddr: expected %h actual %h", exp.paddr, got.paddr); errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status); errors++;
      end
      if (got.lookups !== exp.lookups) begin
        $error("lookups: expected %0d actual %0d", exp.lookups, got.lookups); errors++;
      end
      if (got.hits !== exp.hits) begin
        $error("hits: expected %0d actual %0d", exp.hits, got.hits); errors++;
      end
      if (got.misses !== exp.misses) begin
        $error("misses: expected %0d actual %0d", exp.misses, got.misses); errors++;
      end
    endfunction
  endclass

  logic                clk, rst_n;
  logic                in_valid, in_ready;
  logic [OPCODE_W-1:0] in_opcode;
  logic [VADDR_W-1:0]  in_vaddr;
  logic [FRAME_W-1:0]  in_frame;
  logic                out_valid, out_ready;
  logic [PADDR_W-1:0]  out_paddr;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_lookups, out_hits, out_misses;

  tlb_and_two_level_page_walk dut (.*);

  mmu_scoreboard sb;
  int  idle_cycles;          // watchdog: cycles with no word moving
  bit  calm;                 // no random idling on either side
  bit  sink_hold;            // long receiver hold-off request
  bit  stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = '0; in_vaddr = '0; in_frame = '0;
    out_ready = 1'b0; calm = 1'b0; sink_hold = 1'b0; stim_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Offer one word; hold it until accepted. Random gaps before it, none while calm.
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [VADDR_W-1:0] va,
                           logic [FRAME_W-1:0] frm);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_vaddr  <= va;
    in_frame  <= frm;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, va, frm);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Addresses mostly hit a small working set of pages so the TLB and the
  // walk see repeated, aliasing and mapped pages.
  function automatic logic [VADDR_W-1:0] pick_addr();
    logic [VPN_BITS-1:0] vpn;
    case ($urandom_range(3))
      0: vpn = VPN_BITS'($urandom);
      1: vpn = VPN_BITS'($urandom_range(15));
      default: vpn = {5'($urandom_range(3)), 5'($urandom_range(31))}
                     ^ (10'($urandom_range(1)) << 6); // alias slots
    endcase
    return {vpn, 12'($urandom)};
  endfunction

  // Stimulus
  initial begin
    logic [VADDR_W-1:0] va;
    int k;
    @(posedge clk iff rst_n);
    // Directed: address zero, unmapped walks, map edges, TLB fill/hit,
    // aliasing slots, invalidate of matching and stale tags, opcode three.
    send_word(OPC_XLATE, '0, 10'd1);
    send_word(OPC_XLATE, 22'h3FFFFF, 10'h3FF);
    send_word(OPC_MAP, 22'h3FFFFF, 10'h3FF);
    send_word(OPC_XLATE, 22'h3FFFFF, '0);
    send_word(OPC_XLATE, 22'h3FF000, '0);
    send_word(OPC_MAP, 22'h3FF123, 10'h155);
    send_word(OPC_MAP, 22'h001000, 10'h000);
    send_word(OPC_XLATE, 22'h001abc, '0);
    send_word(OPC_MAP, 22'h000000, 10'h2AA);
    send_word(OPC_XLATE, 22'h000001, '0);
    send_word(OPC_XLATE, 22'h000FFF, '0);
    send_word(OPC_MAP, 22'h040000, 10'h001);   // vpn 64 aliases slot 0
    send_word(OPC_XLATE, 22'h040555, '0);
    send_word(OPC_XLATE, 22'h000555, '0);
    send_word(OPC_INVAL, 22'h040000, '0);      // stale tag, no clear
    send_word(OPC_INVAL, 22'h000000, '0);
    send_word(OPC_XLATE, 22'h000777, '0);
    send_word(OPC_INVAL, 22'h3FF000, '0);
    send_word(OPC_INVAL, 22'h3FF000, '0);      // invalid but tag matches
    send_word(OPC_RSVD, 22'h2AAAAA, 10'h2AA);
    send_word(OPC_RSVD, 22'h155555, 10'h155);
    wait_drained();

    // Random, with a calm stretch and a long receiver hold-off.
    for (k = 0; k < 1600; k++) begin
      if (k == 400) calm = 1'b1;
      if (k == 700) calm = 1'b0;
      if (k == 900) sink_hold = 1'b1;
      if (k == 1200) wait_drained();   // sender pause until all results back
      va = pick_addr();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: send_word(OPC_XLATE, va, FRAME_W'($urandom));
        5, 6, 7:       send_word(OPC_MAP, va, FRAME_W'($urandom));
        8:             send_word(OPC_INVAL, va, FRAME_W'($urandom));
        default:       send_word(OPCODE_W'($urandom_range(3)), VADDR_W'($urandom),
                                 FRAME_W'($urandom));
      endcase
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        for (n = 0; n < 60; n++) @(posedge clk);
        sink_hold = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 14);
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result('{out_paddr, out_status, out_lookups, out_hits, out_misses});
    end
  end

  // Watchdog and end of run. The table clear comes first after reset.
  initial begin
    int tail;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 3000) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (stim_done && sb.pending.size() == 0) begin
        for (tail = 0; tail < 20; tail++) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
          $display("ALL CHECKS PASSED");
        else
          $display("CHECKS FAILED");
        $finish;
      end
    end
  end
endmodule
